@@ src/jp1s_pkg.sv @@
// Package for the 1D Poisson Jacobi solver: widths, reset values,
// command and register codes, and controller state encoding.
// No dependencies.
package jp1s_pkg;

  localparam int VALUE_BITS        = 32;
  localparam int INDEX_BITS        = 11;
  localparam int MAX_INTERVALS_DEF = 1024;

  localparam logic [10:0] MESH_RST  = 11'd1024;
  localparam logic [15:0] SWEEP_RST = 16'd100;
  localparam logic [31:0] STEP_RST  = 32'd4096;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MESH  = 2'd0,
    REG_SWEEP = 2'd1,
    REG_STEP  = 2'd2
  } reg_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_COPY_A = 6'b000100,
    ST_COPY_B = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_DRAIN  = 6'b100000
  } state_e;

endpackage

@@ src/jp1s_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module jp1s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/jp1s_stencil.sv @@
// Two-stage three-point stencil datapath: product and neighbor sum, then
// halving with rounding and saturation. Depends on jp1s_pkg.
module jp1s_stencil import jp1s_pkg::*; #(
  parameter int AW = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [AW-1:0]                in_addr_i,
  input  logic signed [VALUE_BITS-1:0] left_i,
  input  logic signed [VALUE_BITS-1:0] right_i,
  input  logic signed [VALUE_BITS-1:0] f_i,
  input  logic [31:0]                  step_sq_i,
  output logic                         busy_o,
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_addr_o,
  output logic [VALUE_BITS-1:0]        wr_data_o
);

  localparam int SUMW  = VALUE_BITS + 1;
  localparam int PRODW = VALUE_BITS + 32;
  localparam int FULLW = PRODW + 2;
  localparam int SW    = ((SUMW + 16 > PRODW - 16) ? SUMW + 16 : PRODW - 16) + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic                    v1_q;
  logic [AW-1:0]           addr1_q;
  logic signed [SUMW-1:0]  sum_d, sum_q;
  logic signed [PRODW-1:0] prod_d, prod_q;
  logic signed [32:0]      step_s;
  logic signed [FULLW-1:0] prod_full;
  logic signed [SW-1:0]    s_val, t_val, r_val;

  assign step_s    = $signed({1'b0, step_sq_i});
  assign prod_full = f_i * step_s;
  assign prod_d    = prod_full[PRODW-1:0];
  assign sum_d     = SUMW'(left_i) + SUMW'(right_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= in_addr_i;
    sum_q   <= sum_d;
    prod_q  <= prod_d;
  end

  always_comb begin
    s_val = (SW'(sum_q) <<< 16) + SW'(prod_q >>> 16);
    t_val = s_val + SW'(65536);
    r_val = t_val >>> 17;
    if (r_val > SAT_HI) begin
      wr_data_o = SAT_HI[VALUE_BITS-1:0];
    end else if (r_val < SAT_LO) begin
      wr_data_o = SAT_LO[VALUE_BITS-1:0];
    end else begin
      wr_data_o = r_val[VALUE_BITS-1:0];
    end
  end

  assign busy_o    = v1_q;
  assign wr_en_o   = v1_q;
  assign wr_addr_o = addr1_q;

endmodule

@@ src/jacobi_poisson_1d_sweeps.sv @@
// Top level of the 1D Poisson Jacobi solver: configuration registers,
// command sequencer and the three point stores. Depends on jp1s_pkg,
// jp1s_ram and jp1s_stencil.
//
//   Channel   Dir  Word contents
//   s_axis    in   tuser: command; tdata: index, u_value, f_value
//   m_axis    out  tuser: done_res; tdata: index_res, u_value_res
//   apb       in   mesh_intervals @0x0, sweep_count @0x4, step_sq @0x8
//
// A load writes its point directly; a read passes through the store's read register and
// the READ state into the output register. A solve copies the boundary points, then
// runs 2*ceil(sweep_count/2) half sweeps: each half sweep streams n+1 points through the
// single read port of its source store and waits for the stencil pipeline to drain.
// rst_ni is asynchronous; the stores are not cleared and need no clearing pass.
// Input is stalled while a command is in progress or while both result registers hold a word.
module jacobi_poisson_1d_sweeps import jp1s_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // index[10:0], u_value[42:11], f_value[74:43]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // index_res[10:0], u_value_res[42:11]
  output logic        m_axis_tuser,   // done_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_INTERVALS + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [10:0] mesh_q;
  logic [15:0] sweep_q;
  logic [31:0] step_q;
  logic        cfg_wr;

  state_e state_d, state_q;
  logic   out_valid_d, out_valid_q;
  logic [INDEX_BITS-1:0] out_idx_d, out_idx_q;
  logic [VALUE_BITS-1:0] out_val_d, out_val_q;
  logic   out_done_d, out_done_q;
  logic   sk_valid_d, sk_valid_q;
  logic [INDEX_BITS-1:0] sk_idx_d, sk_idx_q;
  logic [VALUE_BITS-1:0] sk_val_d, sk_val_q;
  logic   sk_done_d, sk_done_q;
  logic   res_v;
  logic [INDEX_BITS-1:0] res_idx;
  logic [VALUE_BITS-1:0] res_val;
  logic   res_done;
  logic   out_pop;
  logic [INDEX_BITS-1:0] rd_idx_d, rd_idx_q;
  logic   rd_ok_d, rd_ok_q;
  logic [15:0] pass_d, pass_q;
  logic   phase_d, phase_q;
  logic [AW-1:0] a_d, a_q;
  logic   iss_v_d, iss_v_q;
  logic [AW-1:0] iss_a_d, iss_a_q;
  logic [VALUE_BITS-1:0] prev1_d, prev1_q, prev2_d, prev2_q;

  logic [INDEX_BITS-1:0] in_index;
  logic [VALUE_BITS-1:0] in_u, in_f;
  logic        in_acc, in_ok;
  logic [AW-1:0] in_addr, n_pts;
  logic [16:0] sweep_inc;
  logic [15:0] passes;

  logic          sol_we, scr_we, f_we;
  logic [AW-1:0] sol_waddr, scr_waddr, sol_raddr, scr_raddr, f_raddr;
  logic [VALUE_BITS-1:0] sol_wdata, scr_wdata, sol_rdata, scr_rdata, f_rdata, src_rd;

  logic          st_v, st_busy, st_we;
  logic [AW-1:0] st_addr, st_waddr;
  logic [VALUE_BITS-1:0] st_wdata;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mesh_q  <= MESH_RST;
      sweep_q <= SWEEP_RST;
      step_q  <= STEP_RST;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_MESH:  mesh_q  <= pwdata[10:0];
        REG_SWEEP: sweep_q <= pwdata[15:0];
        REG_STEP:  step_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_MESH:  prdata = {21'd0, mesh_q};
      REG_SWEEP: prdata = {16'd0, sweep_q};
      REG_STEP:  prdata = step_q;
      default:   prdata = '0;
    endcase
  end

  assign in_index = s_axis_tdata[10:0];
  assign in_u     = s_axis_tdata[42:11];
  assign in_f     = s_axis_tdata[74:43];
  assign in_ok    = 32'(in_index) <= 32'(MAX_INTERVALS);
  assign in_addr  = AW'(in_index);

  assign s_axis_tready = (state_q == ST_IDLE) && !sk_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_valid_q && m_axis_tready;

  always_comb begin
    if (mesh_q < 11'd2) begin
      n_pts = AW'(2);
    end else if (32'(mesh_q) > 32'(MAX_INTERVALS)) begin
      n_pts = AW'(MAX_INTERVALS);
    end else begin
      n_pts = AW'(mesh_q);
    end
  end

  assign sweep_inc = {1'b0, sweep_q} + 17'd1;
  assign passes    = sweep_inc[16:1];

  assign src_rd  = phase_q ? scr_rdata : sol_rdata;
  assign st_v    = iss_v_q && (iss_a_q >= AW'(2));
  assign st_addr = iss_a_q - AW'(1);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_done_d  = out_done_q;
    sk_valid_d  = sk_valid_q;
    sk_idx_d    = sk_idx_q;
    sk_val_d    = sk_val_q;
    sk_done_d   = sk_done_q;
    res_v       = 1'b0;
    res_idx     = '0;
    res_val     = '0;
    res_done    = 1'b0;
    rd_idx_d    = rd_idx_q;
    rd_ok_d     = rd_ok_q;
    pass_d      = pass_q;
    phase_d     = phase_q;
    a_d         = a_q;
    iss_v_d     = 1'b0;
    iss_a_d     = iss_a_q;
    prev1_d     = prev1_q;
    prev2_d     = prev2_q;
    sol_we      = 1'b0;
    sol_waddr   = in_addr;
    sol_wdata   = in_u;
    scr_we      = 1'b0;
    scr_waddr   = '0;
    scr_wdata   = sol_rdata;
    f_we        = 1'b0;
    sol_raddr   = a_q;
    scr_raddr   = a_q;
    f_raddr     = a_q - AW'(1);

    if (iss_v_q) begin
      prev2_d = prev1_q;
      prev1_d = src_rd;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(s_axis_tuser))
            CMD_LOAD: begin
              sol_we = in_ok;
              f_we   = in_ok;
            end
            CMD_SOLVE: begin
              sol_raddr = '0;
              state_d   = ST_COPY_A;
            end
            CMD_READ: begin
              sol_raddr = in_addr;
              rd_idx_d  = in_index;
              rd_ok_d   = in_ok;
              state_d   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_v    = 1'b1;
        res_idx  = rd_idx_q;
        res_val  = rd_ok_q ? sol_rdata : '0;
        res_done = 1'b0;
        state_d  = ST_IDLE;
      end
      ST_COPY_A: begin
        scr_we    = 1'b1;
        scr_waddr = '0;
        sol_raddr = n_pts;
        state_d   = ST_COPY_B;
      end
      ST_COPY_B: begin
        scr_we    = 1'b1;
        scr_waddr = n_pts;
        pass_d    = passes;
        phase_d   = 1'b0;
        a_d       = '0;
        if (passes == 16'd0) begin
          res_v    = 1'b1;
          res_done = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        iss_v_d = 1'b1;
        iss_a_d = a_q;
        if (a_q == n_pts) begin
          state_d = ST_DRAIN;
        end else begin
          a_d = a_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!iss_v_q && !st_busy) begin
          a_d = '0;
          if (phase_q) begin
            if (pass_q == 16'd1) begin
              res_v    = 1'b1;
              res_done = 1'b1;
              state_d  = ST_IDLE;
            end else begin
              pass_d  = pass_q - 16'd1;
              phase_d = 1'b0;
              state_d = ST_SWEEP;
            end
          end else begin
            phase_d = 1'b1;
            state_d = ST_SWEEP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // The second result register holds a word that arrives while the output one waits.
    if (!out_valid_q || out_pop) begin
      if (sk_valid_q) begin
        out_valid_d = 1'b1;
        out_idx_d   = sk_idx_q;
        out_val_d   = sk_val_q;
        out_done_d  = sk_done_q;
        sk_valid_d  = res_v;
        sk_idx_d    = res_idx;
        sk_val_d    = res_val;
        sk_done_d   = res_done;
      end else begin
        out_valid_d = res_v;
        out_idx_d   = res_idx;
        out_val_d   = res_val;
        out_done_d  = res_done;
      end
    end else if (res_v) begin
      sk_valid_d = 1'b1;
      sk_idx_d   = res_idx;
      sk_val_d   = res_val;
      sk_done_d  = res_done;
    end

    if (st_we) begin
      if (phase_q) begin
        sol_we    = 1'b1;
        sol_waddr = st_waddr;
        sol_wdata = st_wdata;
      end else begin
        scr_we    = 1'b1;
        scr_waddr = st_waddr;
        scr_wdata = st_wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
      pass_q      <= '0;
      phase_q     <= 1'b0;
      a_q         <= '0;
      iss_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
      pass_q      <= pass_d;
      phase_q     <= phase_d;
      a_q         <= a_d;
      iss_v_q     <= iss_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_done_q <= out_done_d;
    sk_idx_q   <= sk_idx_d;
    sk_val_q   <= sk_val_d;
    sk_done_q  <= sk_done_d;
    rd_idx_q   <= rd_idx_d;
    rd_ok_q    <= rd_ok_d;
    iss_a_q    <= iss_a_d;
    prev1_q    <= prev1_d;
    prev2_q    <= prev2_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_val_q, out_idx_q};
  assign m_axis_tuser  = out_done_q;

  jp1s_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_sol_ram (
    .clk_i  (clk_i),
    .we_i   (sol_we),
    .waddr_i(sol_waddr),
    .wdata_i(sol_wdata),
    .raddr_i(sol_raddr),
    .rdata_o(sol_rdata)
  );

  jp1s_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_scr_ram (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(scr_waddr),
    .wdata_i(scr_wdata),
    .raddr_i(scr_raddr),
    .rdata_o(scr_rdata)
  );

  jp1s_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_f_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(in_addr),
    .wdata_i(in_f),
    .raddr_i(f_raddr),
    .rdata_o(f_rdata)
  );

  jp1s_stencil #(
    .AW(AW)
  ) u_stencil (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(st_v),
    .in_addr_i (st_addr),
    .left_i    (prev2_q),
    .right_i   (src_rd),
    .f_i       (f_rdata),
    .step_sq_i (step_q),
    .busy_o    (st_busy),
    .wr_en_o   (st_we),
    .wr_addr_o (st_waddr),
    .wr_data_o (st_wdata)
  );

endmodule
